### rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file kcit_checker.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication failed");

`endif

### rtl/core/kcit_pkg.sv
// ---------------------------------------------------------------------------
// kcit_pkg
// Types, constants and the key map of the key cursor input tracker.
// ---------------------------------------------------------------------------
package kcit_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int MAP_SIZE    = 20;
    localparam int CFG_DATA_W  = 10;

    typedef enum logic [1:0] {
        OP_SCAN  = 2'd0,
        OP_TICK  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_IDLE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CFG_X_LIMIT      = 2'd0,
        CFG_Y_LIMIT      = 2'd1,
        CFG_ACCEL_PERIOD = 2'd2,
        CFG_ACCEL_MAX    = 2'd3
    } cfg_idx_t;

    localparam logic [9:0] X_LIMIT_RST      = 10'd304;
    localparam logic [7:0] Y_LIMIT_RST      = 8'd184;
    localparam logic [7:0] ACCEL_PERIOD_RST = 8'd10;
    localparam logic [9:0] ACCEL_MAX_RST    = 10'd1023;

    localparam logic [7:0] ARROW_MASK = 8'h8F;
    localparam logic [6:0] MOD_MASK   = 7'h53;
    localparam int         MOD_BIT    = 6;

    localparam logic [6:0] MAP_CODE [MAP_SIZE] = '{
        7'h7C, 7'h7B, 7'h7A, 7'h79, 7'h77, 7'h7E, 7'h7D, 7'h29, 7'h4A, 7'h2B,
        7'h4E, 7'h48, 7'h50, 7'h4B, 7'h4D, 7'h39, 7'h53, 7'h1D, 7'h38, 7'h1C
    };
    localparam logic [7:0] MAP_ACT [MAP_SIZE] = '{
        8'h01, 8'h02, 8'h04, 8'h08, 8'h90, 8'h20, 8'h90, 8'h01, 8'h02, 8'h04,
        8'h08, 8'h01, 8'h02, 8'h04, 8'h08, 8'h90, 8'h50, 8'h41, 8'h42, 8'h90
    };

    typedef struct packed {
        logic       hit;
        logic [7:0] act;
    } key_hit_t;

    // Decoded request as it travels from front to back.
    typedef struct packed {
        op_t        op;
        logic       is_release;
        logic       hit;
        logic [7:0] act;
        logic [6:0] key;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

    // Parallel compare; lowest matching entry wins.
    function automatic key_hit_t key_lookup(logic [6:0] code);
        key_hit_t r;
        r.hit = 1'b0;
        r.act = '0;
        for (int i = MAP_SIZE - 1; i >= 0; i--) begin
            if (MAP_CODE[i] == code) begin
                r.hit = 1'b1;
                r.act = MAP_ACT[i];
            end
        end
        return r;
    endfunction

endpackage

### rtl/core/kcit_front.sv
// ---------------------------------------------------------------------------
// kcit_front
// Accepts requests, decodes scancodes against the key map, feeds the queue.
// ---------------------------------------------------------------------------
module kcit_front (
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [1:0]       operation,
    input  logic [7:0]       scan_code,
    input  kcit_pkg::q_stat_t q_stat,
    output logic             push,
    output kcit_pkg::cmd_t   push_cmd
);

    kcit_pkg::key_hit_t look;

    assign look     = kcit_pkg::key_lookup(scan_code[6:0]);
    assign in_stall = q_stat.full;
    assign push     = in_valid && !q_stat.full;

    always_comb
    begin
        push_cmd.op         = kcit_pkg::op_t'(operation);
        push_cmd.is_release = scan_code[7];
        push_cmd.hit        = look.hit;
        push_cmd.act        = look.act;
        push_cmd.key        = scan_code[6:0];
    end

endmodule

### rtl/core/kcit_queue.sv
// ---------------------------------------------------------------------------
// kcit_queue
// Short FIFO of decoded requests between front and back.
// ---------------------------------------------------------------------------
module kcit_queue #(
    parameter int DEPTH = kcit_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  kcit_pkg::cmd_t    push_cmd,
    input  logic              pop,
    output kcit_pkg::cmd_t    pop_cmd,
    output kcit_pkg::q_stat_t stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    kcit_pkg::cmd_t   entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign pop_cmd    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### rtl/core/kcit_back.sv
// ---------------------------------------------------------------------------
// kcit_back
// Executes decoded requests: key state, cursor motion, button tracking.
// ---------------------------------------------------------------------------
module kcit_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic [1:0]        cfg_index,
    input  logic [kcit_pkg::CFG_DATA_W-1:0] cfg_data,
    input  kcit_pkg::q_stat_t q_stat,
    input  kcit_pkg::cmd_t    cmd,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [9:0]        cursor_x_out,
    output logic [7:0]        cursor_y_out,
    output logic [1:0]        buttons_out,
    output logic              right_flag,
    output logic [6:0]        last_key,
    output logic [6:0]        modifier_bits
);

    logic [9:0] x_limit_reg;
    logic [7:0] y_limit_reg;
    logic [7:0] accel_period_reg;
    logic [9:0] accel_max_reg;

    logic [7:0] arrow_reg,   arrow_next;
    logic [1:0] button_reg,  button_next;
    logic [6:0] special_reg, special_next;
    logic [6:0] held_reg,    held_next;
    logic [7:0] prev_dir_reg, prev_dir_next;
    logic [7:0] count_reg,   count_next;
    logic [9:0] step_reg,    step_next;
    logic [9:0] x_reg,       x_next;
    logic [7:0] y_reg,       y_next;
    logic [1:0] repeat_reg,  repeat_next;
    logic [1:0] shown_reg,   shown_next;
    logic       right_reg,   right_next;
    logic       out_valid_reg, out_valid_next;

    // State doubles as the output payload: it only moves on a pop,
    // and no pop happens while a shown result is stalled.
    assign pop           = !q_stat.empty && (!out_valid_reg || !out_stall);
    assign out_valid     = out_valid_reg;
    assign cursor_x_out  = x_reg;
    assign cursor_y_out  = y_reg;
    assign buttons_out   = shown_reg;
    assign right_flag    = right_reg;
    assign last_key      = held_reg;
    assign modifier_bits = special_reg;

    always_comb
    begin
        logic [7:0]  na;
        logic [7:0]  dir;
        logic [7:0]  cnt_inc;
        logic [9:0]  step_v;
        logic [9:0]  x_v;
        logic [7:0]  y_v;
        logic [10:0] x_sum;
        logic [10:0] y_sum;

        arrow_next    = arrow_reg;
        button_next   = button_reg;
        special_next  = special_reg;
        held_next     = held_reg;
        prev_dir_next = prev_dir_reg;
        count_next    = count_reg;
        step_next     = step_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        repeat_next   = repeat_reg;
        shown_next    = shown_reg;
        right_next    = right_reg;

        na      = ~cmd.act;
        dir     = arrow_reg;
        cnt_inc = count_reg + 8'd1;
        step_v  = step_reg;
        x_v     = x_reg;
        y_v     = y_reg;
        x_sum   = '0;
        y_sum   = '0;

        if (pop)
        begin
            unique case (cmd.op)
                kcit_pkg::OP_SCAN:
                begin
                    held_next = cmd.key;
                    if (cmd.hit)
                    begin
                        if (cmd.is_release)
                        begin
                            held_next = '0;
                            if (!na[kcit_pkg::MOD_BIT])
                            begin
                                special_next = special_reg & na[6:0];
                            end
                            arrow_next  = arrow_reg & na & kcit_pkg::ARROW_MASK;
                            button_next = button_reg & na[5:4];
                        end
                        else if (cmd.act[kcit_pkg::MOD_BIT])
                        begin
                            special_next = (special_reg | cmd.act[6:0]) & kcit_pkg::MOD_MASK;
                        end
                        else
                        begin
                            arrow_next  = arrow_reg | (cmd.act & kcit_pkg::ARROW_MASK);
                            button_next = button_reg | cmd.act[5:4];
                        end
                    end
                    else if (cmd.is_release)
                    begin
                        held_next = '0;
                    end
                end
                kcit_pkg::OP_TICK:
                begin
                    // acceleration
                    if (dir != '0 && dir == prev_dir_reg)
                    begin
                        if (cnt_inc == accel_period_reg)
                        begin
                            count_next = '0;
                            if (step_reg < accel_max_reg)
                            begin
                                step_v = step_reg + 10'd1;
                            end
                        end
                        else
                        begin
                            count_next = cnt_inc;
                        end
                    end
                    else
                    begin
                        step_v     = 10'd1;
                        count_next = '0;
                    end
                    step_next     = step_v;
                    prev_dir_next = dir;

                    // right then left, down then up
                    if (dir[3])
                    begin
                        x_sum = {1'b0, x_v} + {1'b0, step_v};
                        x_v   = (x_sum >= {1'b0, x_limit_reg}) ? x_limit_reg : x_sum[9:0];
                    end
                    if (dir[2])
                    begin
                        x_v = (x_v > step_v) ? x_v - step_v : '0;
                    end
                    if (dir[1])
                    begin
                        y_sum = {3'b0, y_v} + {1'b0, step_v};
                        y_v   = (y_sum >= {3'b0, y_limit_reg}) ? y_limit_reg : y_sum[7:0];
                    end
                    if (dir[0])
                    begin
                        y_v = ({2'b0, y_v} > step_v) ? y_v - step_v[7:0] : '0;
                    end
                    x_next = x_v;
                    y_next = y_v;

                    // repeat suppression
                    if (button_reg != '0 && repeat_reg != '0)
                    begin
                        shown_next = '0;
                    end
                    else
                    begin
                        if (button_reg[1])
                        begin
                            right_next = 1'b1;
                        end
                        if (button_reg[0])
                        begin
                            right_next = 1'b0;
                        end
                        shown_next  = button_reg;
                        repeat_next = button_reg;
                    end
                end
                kcit_pkg::OP_CLEAR:
                begin
                    arrow_next  = '0;
                    button_next = '0;
                    repeat_next = '0;
                end
                kcit_pkg::OP_IDLE:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_limit_reg      <= kcit_pkg::X_LIMIT_RST;
            y_limit_reg      <= kcit_pkg::Y_LIMIT_RST;
            accel_period_reg <= kcit_pkg::ACCEL_PERIOD_RST;
            accel_max_reg    <= kcit_pkg::ACCEL_MAX_RST;
        end
        else if (cfg_write)
        begin
            unique case (kcit_pkg::cfg_idx_t'(cfg_index))
                kcit_pkg::CFG_X_LIMIT:      x_limit_reg      <= cfg_data;
                kcit_pkg::CFG_Y_LIMIT:      y_limit_reg      <= cfg_data[7:0];
                kcit_pkg::CFG_ACCEL_PERIOD: accel_period_reg <= cfg_data[7:0];
                kcit_pkg::CFG_ACCEL_MAX:    accel_max_reg    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arrow_reg     <= '0;
            button_reg    <= '0;
            special_reg   <= '0;
            held_reg      <= '0;
            prev_dir_reg  <= '0;
            count_reg     <= '0;
            step_reg      <= 10'd1;
            x_reg         <= '0;
            y_reg         <= '0;
            repeat_reg    <= '0;
            shown_reg     <= '0;
            right_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            arrow_reg     <= arrow_next;
            button_reg    <= button_next;
            special_reg   <= special_next;
            held_reg      <= held_next;
            prev_dir_reg  <= prev_dir_next;
            count_reg     <= count_next;
            step_reg      <= step_next;
            x_reg         <= x_next;
            y_reg         <= y_next;
            repeat_reg    <= repeat_next;
            shown_reg     <= shown_next;
            right_reg     <= right_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### rtl/core/key_cursor_input_tracker_top.sv
// ---------------------------------------------------------------------------
// key_cursor_input_tracker_top
// Keyboard scancode tracker with an accelerated, clamped cursor.
// ---------------------------------------------------------------------------
// Input channel (in_valid/in_stall): operation (scancode, tick, clear) and
// scan_code. Every request yields exactly one result on the output channel
// (out_valid/out_stall): cursor position, buttons, right flag, held key and
// modifier bits as they stand after that request.
// Throughput: one request per cycle while the output is not stalled. The
// front decodes the scancode against the key map and writes a small queue;
// the back applies one request per cycle from the queue unless a shown
// result is stalled, its state update being the loop that sets that rate.
// With the queue empty and no result waiting, an accepted request is queued,
// then popped into the back's state registers, raising out_valid. A stalled
// result holds its payload; the queue then fills and in_stall rises once it
// holds QUEUE_DEPTH requests. Reset clears key, button and cursor state,
// sets the step to one and loads the register defaults (x_limit 304, y_limit
// 184, period 10, max 1023). The user is to write registers only while
// idle, through cfg_write/cfg_index/cfg_data; the block does not enforce it.
// ---------------------------------------------------------------------------
module key_cursor_input_tracker_top #(
    parameter int QUEUE_DEPTH = kcit_pkg::QUEUE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic [1:0] cfg_index,
    input  logic [kcit_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] operation,
    input  logic [7:0] scan_code,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [9:0] cursor_x_out,
    output logic [7:0] cursor_y_out,
    output logic [1:0] buttons_out,
    output logic       right_flag,
    output logic [6:0] last_key,
    output logic [6:0] modifier_bits
);

    kcit_pkg::q_stat_t q_stat;
    kcit_pkg::cmd_t    push_cmd;
    kcit_pkg::cmd_t    pop_cmd;
    logic              push;
    logic              pop;

    kcit_front u_front (
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .scan_code (scan_code),
        .q_stat    (q_stat),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    kcit_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .stat     (q_stat)
    );

    kcit_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .q_stat        (q_stat),
        .cmd           (pop_cmd),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .cursor_x_out  (cursor_x_out),
        .cursor_y_out  (cursor_y_out),
        .buttons_out   (buttons_out),
        .right_flag    (right_flag),
        .last_key      (last_key),
        .modifier_bits (modifier_bits)
    );

endmodule

### rtl/core/kcit_checker.sv
// ---------------------------------------------------------------------------
// kcit_checker
// Port-level checks of the key cursor input tracker, bound to the top.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module kcit_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [9:0] cursor_x_out,
    input logic [7:0] cursor_y_out,
    input logic [1:0] buttons_out,
    input logic       right_flag,
    input logic [6:0] last_key,
    input logic [6:0] modifier_bits
);

    // stalled result keeps valid and payload
    `ASSERT_ALWAYS(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(cursor_x_out) && $stable(cursor_y_out) && $stable(buttons_out) && $stable(right_flag) && $stable(last_key) && $stable(modifier_bits))

    // only the defined modifier bits can ever be set
    `ASSERT_IMPLY(a_mod_mask, clk, rst_n, out_valid, (modifier_bits & ~kcit_pkg::MOD_MASK) == 7'h0)

    // an accepted request raises out_valid once through the queue and back registers
    `ASSERT_ALWAYS(a_latency, clk, rst_n, in_valid && !in_stall |-> ##2 out_valid)

endmodule

bind key_cursor_input_tracker_top kcit_checker u_checker (.*);

### test/key_cursor_input_tracker_checker.sv
// ----------------------------------------------------------------------------
// key_cursor_input_tracker_checker
// Watches the request, result and register ports of the tracker. It keeps its
// own copy of the key, button, acceleration and cursor state, predicts the
// snapshot for each accepted request and compares each accepted result with
// the oldest prediction.
// ----------------------------------------------------------------------------
module key_cursor_input_tracker_checker
    import kcit_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic [1:0]            operation,
    input  logic [7:0]            scan_code,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic [9:0]            cursor_x_out,
    input  logic [7:0]            cursor_y_out,
    input  logic [1:0]            buttons_out,
    input  logic                  right_flag,
    input  logic [6:0]            last_key,
    input  logic [6:0]            modifier_bits,
    output int                    mismatches,
    output int                    awaiting
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [9:0] x;
        logic [7:0] y;
        logic [1:0] buttons;
        logic       right;
        logic [6:0] key;
        logic [6:0] mods;
    } snapshot_t;

    snapshot_t pending_snapshots[$];

    // register copies
    logic [9:0] lim_x;
    logic [7:0] lim_y;
    logic [7:0] grow_period;
    logic [9:0] step_max;

    // tracker state
    logic [7:0] arrows;
    logic [1:0] held_buttons;
    logic [6:0] mod_bits;
    logic [6:0] key_now;
    logic [7:0] last_dir;
    logic [7:0] tick_count;
    logic [9:0] step;
    logic [9:0] cur_x;
    logic [7:0] cur_y;
    logic [1:0] btn_latch;
    logic [1:0] shown_btn;
    logic       right_last;

    // {hit, action} for a 7-bit key code
    function automatic logic [8:0] key_action(input logic [6:0] code);
        case (code)
            7'h7C: return {1'b1, 8'h01};
            7'h7B: return {1'b1, 8'h02};
            7'h7A: return {1'b1, 8'h04};
            7'h79: return {1'b1, 8'h08};
            7'h77: return {1'b1, 8'h90};
            7'h7E: return {1'b1, 8'h20};
            7'h7D: return {1'b1, 8'h90};
            7'h29: return {1'b1, 8'h01};
            7'h4A: return {1'b1, 8'h02};
            7'h2B: return {1'b1, 8'h04};
            7'h4E: return {1'b1, 8'h08};
            7'h48: return {1'b1, 8'h01};
            7'h50: return {1'b1, 8'h02};
            7'h4B: return {1'b1, 8'h04};
            7'h4D: return {1'b1, 8'h08};
            7'h39: return {1'b1, 8'h90};
            7'h53: return {1'b1, 8'h50};
            7'h1D: return {1'b1, 8'h41};
            7'h38: return {1'b1, 8'h42};
            7'h1C: return {1'b1, 8'h90};
            default: return 9'd0;
        endcase
    endfunction

    task automatic apply_request(input op_t op, input logic [7:0] code);
        logic [8:0]  lookup;
        logic [7:0]  act;
        logic [7:0]  inv;
        logic [10:0] sum;
        case (op)
            OP_SCAN:
            begin
                lookup  = key_action(code[6:0]);
                act     = lookup[7:0];
                key_now = code[6:0];
                if (lookup[8])
                begin
                    if (code[7])
                    begin
                        inv     = ~act;
                        key_now = '0;
                        if (!inv[MOD_BIT])
                            mod_bits = mod_bits & inv[6:0];
                        arrows       = arrows & inv & ARROW_MASK;
                        held_buttons = held_buttons & inv[5:4];
                    end
                    else if (act[MOD_BIT])
                    begin
                        mod_bits = (mod_bits | act[6:0]) & MOD_MASK;
                    end
                    else
                    begin
                        arrows       = arrows | (act & ARROW_MASK);
                        held_buttons = held_buttons | act[5:4];
                    end
                end
                else if (code[7])
                begin
                    key_now = '0;
                end
            end
            OP_TICK:
            begin
                if (arrows != 0 && arrows == last_dir)
                begin
                    tick_count = tick_count + 8'd1;
                    if (tick_count == grow_period)
                    begin
                        if (step < step_max)
                            step = step + 10'd1;
                        tick_count = '0;
                    end
                end
                else
                begin
                    step       = 10'd1;
                    tick_count = '0;
                end
                last_dir = arrows;

                if (arrows[3])
                begin
                    sum   = {1'b0, cur_x} + {1'b0, step};
                    cur_x = (sum >= {1'b0, lim_x}) ? lim_x : sum[9:0];
                end
                if (arrows[2])
                    cur_x = (cur_x > step) ? cur_x - step : '0;
                if (arrows[1])
                begin
                    sum   = {3'b0, cur_y} + {1'b0, step};
                    cur_y = (sum >= {3'b0, lim_y}) ? lim_y : sum[7:0];
                end
                if (arrows[0])
                    cur_y = ({2'b0, cur_y} > step) ? cur_y - step[7:0] : '0;

                // held button with a latched one: hide it, keep the latch
                if (held_buttons != 0 && btn_latch != 0)
                begin
                    shown_btn = '0;
                end
                else
                begin
                    if (held_buttons[1])
                        right_last = 1'b1;
                    if (held_buttons[0])
                        right_last = 1'b0;
                    shown_btn = held_buttons;
                    btn_latch = held_buttons;
                end
            end
            OP_CLEAR:
            begin
                arrows       = '0;
                held_buttons = '0;
                btn_latch    = '0;
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [9:0] want, input logic [9:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        snapshot_t got;
        snapshot_t want;
        if (!rst_n)
        begin
            lim_x        = X_LIMIT_RST;
            lim_y        = Y_LIMIT_RST;
            grow_period  = ACCEL_PERIOD_RST;
            step_max     = ACCEL_MAX_RST;
            arrows       = '0;
            held_buttons = '0;
            mod_bits     = '0;
            key_now      = '0;
            last_dir     = '0;
            tick_count   = '0;
            step         = 10'd1;
            cur_x        = '0;
            cur_y        = '0;
            btn_latch    = '0;
            shown_btn    = '0;
            right_last   = 1'b0;
            pending_snapshots.delete();
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_X_LIMIT:      lim_x       = cfg_data[9:0];
                    CFG_Y_LIMIT:      lim_y       = cfg_data[7:0];
                    CFG_ACCEL_PERIOD: grow_period = cfg_data[7:0];
                    CFG_ACCEL_MAX:    step_max    = cfg_data[9:0];
                    default:
                    begin
                    end
                endcase
            end
            if (in_valid && !in_stall)
            begin
                apply_request(op_t'(operation), scan_code);
                pending_snapshots.push_back('{cur_x, cur_y, shown_btn, right_last,
                                              key_now, mod_bits});
            end
            if (out_valid && !out_stall)
            begin
                got = '{cursor_x_out, cursor_y_out, buttons_out, right_flag,
                        last_key, modifier_bits};
                if (pending_snapshots.size() == 0)
                begin
                    $display("%0t: result with no request pending: expected none, got %h",
                             $time, got);
                    mismatches++;
                end
                else
                begin
                    want = pending_snapshots.pop_front();
                    check_field("cursor_x_out", 10'(want.x), 10'(got.x));
                    check_field("cursor_y_out", 10'(want.y), 10'(got.y));
                    check_field("buttons_out", 10'(want.buttons), 10'(got.buttons));
                    check_field("right_flag", 10'(want.right), 10'(got.right));
                    check_field("last_key", 10'(want.key), 10'(got.key));
                    check_field("modifier_bits", 10'(want.mods), 10'(got.mods));
                end
            end
        end
        awaiting = pending_snapshots.size();
    end

endmodule

### test/key_cursor_input_tracker_top_tb.sv
// ----------------------------------------------------------------------------
// key_cursor_input_tracker_top_tb
// Drives scancode, tick, clear and idle requests into the tracker: a short
// directed run through the key map quirks, then random key sequences under
// several register settings and idle mixes, with one long output hold-off
// per phase. The checker beside the block predicts and compares each result.
// ----------------------------------------------------------------------------
module key_cursor_input_tracker_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import kcit_pkg::*;

    localparam int HOLD_CYCLES    = 60;
    localparam int WATCHDOG_LIMIT = 2000;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_write;
    logic [1:0]            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [1:0]            operation;
    logic [7:0]            scan_code;
    logic                  out_valid;
    logic                  out_stall;
    logic [9:0]            cursor_x_out;
    logic [7:0]            cursor_y_out;
    logic [1:0]            buttons_out;
    logic                  right_flag;
    logic [6:0]            last_key;
    logic [6:0]            modifier_bits;

    int fail_count;
    int awaiting;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_requests;
    int holds_served;
    int requests_sent;
    int quiet_cycles;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    key_cursor_input_tracker_top dut (.*);

    key_cursor_input_tracker_checker tracker_check (
        .mismatches (fail_count),
        .awaiting   (awaiting),
        .*
    );

    // receiver: random stalls, plus long hold-offs on request
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_served < hold_requests)
            begin
                holds_served++;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[key_cursor_input_tracker_top] ERROR");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_request(input op_t op, input logic [7:0] code);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        scan_code <= code;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (op != OP_IDLE)
            requests_sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (awaiting != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic load_settings(input logic [9:0] x_lim, input logic [7:0] y_lim,
                                 input logic [7:0] period, input logic [9:0] step_cap);
        drain_results();
        write_register(CFG_X_LIMIT, x_lim);
        write_register(CFG_Y_LIMIT, 10'(y_lim));
        write_register(CFG_ACCEL_PERIOD, 10'(period));
        write_register(CFG_ACCEL_MAX, step_cap);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // press a few mapped keys, tick while held, then release most of them
    task automatic key_sequence();
        logic [6:0] keys [3];
        int         count;
        int         ticks;
        count = $urandom_range(1, 3);
        for (int i = 0; i < count; i++)
        begin
            keys[i] = MAP_CODE[$urandom_range(MAP_SIZE - 1)];
            send_request(OP_SCAN, {1'b0, keys[i]});
        end
        ticks = ($urandom_range(99) < 2) ? $urandom_range(256, 300) : $urandom_range(1, 30);
        repeat (ticks) send_request(OP_TICK, 8'($urandom));
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(3) != 0)
                send_request(OP_SCAN, {1'b1, keys[i]});
            if ($urandom_range(1) != 0)
                send_request(OP_TICK, 8'($urandom));
        end
    endtask

    task automatic broken_sequence();
        case ($urandom_range(2))
            0: send_request(OP_SCAN, {1'b1, MAP_CODE[$urandom_range(MAP_SIZE - 1)]});
            1:
            begin
                send_request(OP_SCAN, {1'b0, MAP_CODE[$urandom_range(MAP_SIZE - 1)]});
                send_request(OP_CLEAR, 8'($urandom));
            end
            default: send_request(OP_SCAN, {1'b0, 7'($urandom)});
        endcase
        send_request(OP_TICK, 8'($urandom));
    endtask

    task automatic random_phase(input int count);
        int  target;
        int  pick;
        bit  held;
        target = requests_sent + count;
        held   = 1'b0;
        while (requests_sent < target)
        begin
            // one long output hold-off midway while requests keep coming
            if (!held && requests_sent >= target - count / 2)
            begin
                hold_requests++;
                held = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 70)
                key_sequence();
            else if (pick < 88)
                send_request(op_t'($urandom_range(3)), 8'($urandom));
            else
                broken_sequence();
        end
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        operation <= OP_SCAN;
        scan_code <= '0;
        cfg_write <= 1'b0;
        cfg_index <= CFG_X_LIMIT;
        cfg_data  <= '0;
        send_idle_pct = 36;
        recv_idle_pct = 87;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // tight limits so clamps and step saturation show up quickly
        load_settings(10'd6, 8'd2, 8'd1, 10'd3);
        send_request(OP_IDLE, 8'hFF);
        send_request(OP_SCAN, 8'h00);
        send_request(OP_SCAN, 8'h7F);
        send_request(OP_SCAN, 8'h80);
        send_request(OP_SCAN, 8'h1D);
        send_request(OP_SCAN, 8'h38);
        send_request(OP_SCAN, 8'h53);
        send_request(OP_SCAN, 8'h9D);
        send_request(OP_SCAN, 8'h4D);
        send_request(OP_SCAN, 8'h50);
        send_request(OP_SCAN, 8'h39);
        repeat (4) send_request(OP_TICK, 8'hFF);
        send_request(OP_SCAN, 8'h7E);
        send_request(OP_TICK, 8'h00);
        // releasing the space key drops the left button bit and arrow bit 7
        send_request(OP_SCAN, 8'hB9);
        send_request(OP_TICK, 8'h00);
        send_request(OP_CLEAR, 8'hFF);
        send_request(OP_TICK, 8'h00);
        send_request(OP_SCAN, 8'h7E);
        send_request(OP_TICK, 8'h55);
        send_request(OP_SCAN, 8'h4B);
        send_request(OP_SCAN, 8'h48);
        repeat (2) send_request(OP_TICK, 8'hAA);
        send_request(OP_SCAN, 8'hFF);

        load_settings(10'd1023, 8'd255, 8'd1, 10'd1023);
        random_phase(350);
        load_settings(10'd0, 8'd0, 8'd255, 10'd1);
        random_phase(150);

        send_idle_pct = 87;
        recv_idle_pct = 36;
        load_settings(X_LIMIT_RST, Y_LIMIT_RST, ACCEL_PERIOD_RST, ACCEL_MAX_RST);
        random_phase(350);
        // zero period: step only grows after the count wraps
        load_settings(10'd37, 8'd21, 8'd0, 10'd4);
        random_phase(250);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        load_settings(10'($urandom_range(1023)), 8'($urandom_range(255)),
                      8'($urandom_range(1, 8)), 10'($urandom_range(1, 1023)));
        random_phase(350);

        drain_results();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && awaiting == 0)
        begin
            $display("[key_cursor_input_tracker_top] OK");
        end
        else
        begin
            $display("[key_cursor_input_tracker_top] ERROR");
        end
        $finish;
    end

endmodule
